>>> src/hashed_value_noise_2d_top_assert.svh
// Assertion macros shared by the hashed value noise RTL.
`ifndef HASHED_VALUE_NOISE_2D_TOP_ASSERT_SVH
`define HASHED_VALUE_NOISE_2D_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Clocked assertion with explicit clock and active-low reset.
`define HVN2D_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Same, on the block clock and reset.
`define HVN2D_ASSERT(lbl, prop, msg) `HVN2D_ASSERT_CLK(lbl, aclk, aresetn, prop, msg)
`else
`define HVN2D_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define HVN2D_ASSERT(lbl, prop, msg)
`endif
`endif

>>> src/hvn2d_pkg.sv
// Constants and types for the hashed value noise pipeline.
`default_nettype none
package hvn2d_pkg;

    // Corner hash multipliers
    localparam logic [31:0] HASH_MUL_X = 32'd374761393;
    localparam logic [31:0] HASH_MUL_Y = 32'd668265263;
    localparam logic [31:0] HASH_MUL_S = 32'd2246822519;
    localparam logic [31:0] HASH_MUL_M = 32'd1274126177;

    // Register stages from input word to output word
    localparam int NUM_STAGES = 7;
    // Four lattice corners: 0 = (x,y), 1 = (x+1,y), 2 = (x,y+1), 3 = (x+1,y+1)
    localparam int NUM_CORNERS = 4;

    typedef logic [15:0] corner_t;   // corner value, Q0.16
    typedef logic [15:0] frac_t;     // fraction, Q0.16
    typedef logic [16:0] weight_t;   // blend weight, 0..65536

endpackage
`default_nettype wire

>>> src/hashed_value_noise_2d_top.sv
// Top level: pipelined 2D hashed value noise with smoothstep blending.
//
//  channel | dir | handshake                    | payload
//  --------+-----+------------------------------+----------------------------------------
//  s_axis  | in  | s_axis_tvalid/s_axis_tready  | tdata[31:0] coord_x, [63:32] coord_y
//  m_axis  | out | m_axis_tvalid/m_axis_tready  | tdata[15:0] noise_value
//  cfg     | in  | cfg_wr_en (no wait)          | cfg_wr_data = noise_seed
//
// One word per cycle sustained while m_axis_tready stays high. Seven register stages,
// input register through output register. The depth is set by the chain of 32x32 hash
// multiplies and the two-level blend multiplies, each followed by a register.
// Every stage has its own valid bit and advances when the next stage is empty
// or advancing, so bubbles close up and a stalled output holds only the stages
// behind it that are full.
// aresetn is synchronous, active low: clears valid bits and the seed.
`default_nettype none
`include "hashed_value_noise_2d_top_assert.svh"
module hashed_value_noise_2d_top #(
    parameter int FRAC_BITS = 16   // fraction bits of the coordinates, 8..24
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // seed register write
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,   // noise_seed
    // input words
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,  // [31:0] coord_x, [63:32] coord_y
    // result words
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata   // [15:0] noise_value
);

    localparam int NS = hvn2d_pkg::NUM_STAGES;
    localparam int NC = hvn2d_pkg::NUM_CORNERS;

    // ---------------------------------------------------------------
    // Seed: only its product with the seed multiplier is ever used,
    // so that product is what gets stored.
    // ---------------------------------------------------------------
    logic [31:0] seed_mix_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_mix_reg <= '0;
        end else if (cfg_wr_en) begin
            seed_mix_reg <= cfg_wr_data * hvn2d_pkg::HASH_MUL_S;
        end
    end

    // ---------------------------------------------------------------
    // Flow control: per-stage valid and advance
    // ---------------------------------------------------------------
    logic [NS-1:0] valid_reg;
    logic [NS-1:0] stage_en;

    always_comb begin
        stage_en[NS-1] = !valid_reg[NS-1] || m_axis_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (stage_en[0]) begin
                valid_reg[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NS; k++) begin
                if (stage_en[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    assign s_axis_tready = stage_en[0];
    assign m_axis_tvalid = valid_reg[NS-1];

    // ---------------------------------------------------------------
    // Stage 1: input register
    // ---------------------------------------------------------------
    logic [31:0] cx_reg, cy_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            cx_reg <= s_axis_tdata[31:0];
            cy_reg <= s_axis_tdata[63:32];
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: floor, lattice multiplies, fraction to Q0.16
    // ---------------------------------------------------------------
    logic [31:0]      ix, iy;
    hvn2d_pkg::frac_t fx_next, fy_next;
    logic [31:0]      px_reg, py_reg;
    hvn2d_pkg::frac_t fx_reg, fy_reg;

    // arithmetic shift is the floor for negative points too
    assign ix = 32'($signed(cx_reg) >>> FRAC_BITS);
    assign iy = 32'($signed(cy_reg) >>> FRAC_BITS);

    generate
        if (FRAC_BITS >= 16) begin : g_frac_trunc
            assign fx_next = cx_reg[FRAC_BITS-1 -: 16];
            assign fy_next = cy_reg[FRAC_BITS-1 -: 16];
        end else begin : g_frac_widen
            assign fx_next = {cx_reg[FRAC_BITS-1:0], {(16 - FRAC_BITS){1'b0}}};
            assign fy_next = {cy_reg[FRAC_BITS-1:0], {(16 - FRAC_BITS){1'b0}}};
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            px_reg <= ix * hvn2d_pkg::HASH_MUL_X;
            py_reg <= iy * hvn2d_pkg::HASH_MUL_Y;
            fx_reg <= fx_next;
            fy_reg <= fy_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: corner hash input and first xorshift; fraction squared.
    // (i+1)*M is i*M + M, so the +1 corners need only an add.
    // ---------------------------------------------------------------
    logic [31:0]      hx1, hy1;
    logic [31:0]      hash_in [NC];
    logic [31:0]      mix_reg [NC];
    logic [31:0]      sqx_reg, sqy_reg;
    hvn2d_pkg::frac_t fx3_reg, fy3_reg;

    assign hx1 = px_reg + hvn2d_pkg::HASH_MUL_X;
    assign hy1 = py_reg + hvn2d_pkg::HASH_MUL_Y;

    always_comb begin
        hash_in[0] = px_reg ^ py_reg ^ seed_mix_reg;
        hash_in[1] = hx1    ^ py_reg ^ seed_mix_reg;
        hash_in[2] = px_reg ^ hy1    ^ seed_mix_reg;
        hash_in[3] = hx1    ^ hy1    ^ seed_mix_reg;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            for (int c = 0; c < NC; c++) begin
                mix_reg[c] <= hash_in[c] ^ (hash_in[c] >> 13);
            end
            sqx_reg <= fx_reg * fx_reg;
            sqy_reg <= fy_reg * fy_reg;
            fx3_reg <= fx_reg;
            fy3_reg <= fy_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: final hash multiply; the last xorshift leaves the top
    // half unchanged, so the corner value is the product's top half.
    // Fraction cubed.
    // ---------------------------------------------------------------
    logic [31:0]        hash_mul [NC];
    hvn2d_pkg::corner_t corner_reg [NC];
    logic [47:0]        cubx_reg, cuby_reg;
    logic [31:0]        sqx4_reg, sqy4_reg;

    always_comb begin
        for (int c = 0; c < NC; c++) begin
            hash_mul[c] = mix_reg[c] * hvn2d_pkg::HASH_MUL_M;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            for (int c = 0; c < NC; c++) begin
                corner_reg[c] <= hash_mul[c][31:16];
            end
            cubx_reg <= sqx_reg * 48'(fx3_reg);
            cuby_reg <= sqy_reg * 48'(fy3_reg);
            sqx4_reg <= sqx_reg;
            sqy4_reg <= sqy_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 5: smoothstep s = (3 f^2 2^16 - 2 f^3) >> 32 and weights
    // ---------------------------------------------------------------
    logic [49:0]        smx_full, smy_full;
    hvn2d_pkg::frac_t   sx_reg, sy_reg;
    hvn2d_pkg::weight_t rx_reg, ry_reg;
    hvn2d_pkg::corner_t corner5_reg [NC];

    assign smx_full = {(34'(sqx4_reg) * 34'd3), 16'h0000} - {1'b0, cubx_reg, 1'b0};
    assign smy_full = {(34'(sqy4_reg) * 34'd3), 16'h0000} - {1'b0, cuby_reg, 1'b0};

    always_ff @(posedge aclk) begin
        if (stage_en[4]) begin
            sx_reg <= smx_full[47:32];
            sy_reg <= smy_full[47:32];
            rx_reg <= 17'h10000 - {1'b0, smx_full[47:32]};
            ry_reg <= 17'h10000 - {1'b0, smy_full[47:32]};
            for (int c = 0; c < NC; c++) begin
                corner5_reg[c] <= corner_reg[c];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 6: blend along x, exact (below 2^32)
    // ---------------------------------------------------------------
    logic [33:0]        lerp0_full, lerp1_full;
    logic [31:0]        lerp0_reg, lerp1_reg;
    hvn2d_pkg::frac_t   sy6_reg;
    hvn2d_pkg::weight_t ry6_reg;

    assign lerp0_full = 34'(corner5_reg[0]) * 34'(rx_reg) + 34'(corner5_reg[1]) * 34'(sx_reg);
    assign lerp1_full = 34'(corner5_reg[2]) * 34'(rx_reg) + 34'(corner5_reg[3]) * 34'(sx_reg);

    always_ff @(posedge aclk) begin
        if (stage_en[5]) begin
            lerp0_reg <= lerp0_full[31:0];
            lerp1_reg <= lerp1_full[31:0];
            sy6_reg   <= sy_reg;
            ry6_reg   <= ry_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 7: blend along y, truncate, saturate; output register
    // ---------------------------------------------------------------
    logic [49:0] acc;
    logic [15:0] noise_reg;

    assign acc = 50'(lerp0_reg) * 50'(ry6_reg) + 50'(lerp1_reg) * 50'(sy6_reg);

    always_ff @(posedge aclk) begin
        if (stage_en[6]) begin
            noise_reg <= (acc[49:48] != 2'b00) ? 16'hFFFF : acc[47:32];
        end
    end

    assign m_axis_tdata = noise_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `HVN2D_ASSERT(a_full_stall_blocks_input,
        (&valid_reg) && !m_axis_tready |-> !s_axis_tready,
        "pipeline full and stalled but input ready")
    `HVN2D_ASSERT(a_accept_fills_stage1,
        s_axis_tvalid && s_axis_tready |=> valid_reg[0],
        "accepted word not in first stage")
    `HVN2D_ASSERT(a_stalled_corners_hold,
        valid_reg[3] && !stage_en[3] |=>
            valid_reg[3] && $stable(corner_reg[0]) && $stable(corner_reg[3]),
        "stalled corner stage lost its word")
    `HVN2D_ASSERT(a_weights_sum_one,
        valid_reg[4] |-> ({1'b0, sx_reg} + rx_reg == 17'h10000) &&
            ({1'b0, sy_reg} + ry_reg == 17'h10000),
        "blend weights do not sum to one")

endmodule
`default_nettype wire
